FILE: src/kwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg: shared definitions for the k-way merge min-heap unit
// Command and status codes, field widths and the heap entry layout.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int CMD_W  = 3;
  localparam int SRC_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam int MAX_LISTS_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADVANCE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXHAUSTED = 3'd4;

  localparam logic [STAT_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd3;

  // One heap entry as it sits in the memory: list number above the value.
  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [VAL_W-1:0] val;
  } heap_entry_t;

endpackage

FILE: src/kwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_in_if / kwm_out_if: command and result channels
// Valid/ready channels carrying one command word or one result word.
// ----------------------------------------------------------------------------
interface kwm_in_if;
  logic                        valid;
  logic                        ready;
  logic [kwm_pkg::CMD_W-1:0]   cmd;
  logic [kwm_pkg::SRC_W-1:0]   list_id;
  logic signed [kwm_pkg::VAL_W-1:0] value;

  modport source (output valid, output cmd, output list_id, output value, input ready);
  modport sink   (input valid, input cmd, input list_id, input value, output ready);
endinterface

interface kwm_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [kwm_pkg::VAL_W-1:0] out_value;
  logic [kwm_pkg::SRC_W-1:0]   source_list;
  logic [kwm_pkg::STAT_W-1:0]  status;

  modport source (output valid, output out_value, output source_list, output status,
                  input ready);
  modport sink   (input valid, input out_value, input source_list, input status,
                  output ready);
endinterface

FILE: src/kway_merge_min_heap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_min_heap_unit: k-way merge engine on a binary min-heap
// Keeps list heads in a heap memory and reports the smallest head.
// ----------------------------------------------------------------------------
// The unit takes one command word at a time and answers each with exactly one
// result word. Clear and load go from acceptance straight to handing over the
// result. An advance or exhausted command fetches the entry that starts the
// sift, reads its children, then compares once per heap level the sift-down
// visits (at most floor(log2(n)) + 1 levels for n entries), reads the root and
// hands it on. Each level uses the heap memory once: its two read ports fetch
// both children while the write port stores the entry that moves up.
// A start command runs one such sift for each inner node, n/2 of them. A new
// command is taken as soon as the previous one has produced its result, even
// if that result word is still waiting in the output register.

module kway_merge_min_heap_unit #(
  parameter int MAX_LISTS = kwm_pkg::MAX_LISTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  kwm_in_if.sink       in_ch,
  kwm_out_if.source    out_ch
);

  localparam int AW = $clog2(MAX_LISTS);      // heap index
  localparam int CW = $clog2(MAX_LISTS + 1);  // entry count
  localparam int KW = AW + 2;                 // child index, may pass the end
  localparam int EW = $bits(kwm_pkg::heap_entry_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;  // read the entry that starts a sift
  localparam logic [2:0] S_TAKE  = 3'd2;  // hold it, read its children
  localparam logic [2:0] S_CMP   = 3'd3;  // pick the smaller child, move it up
  localparam logic [2:0] S_ROOT  = 3'd4;  // read the root
  localparam logic [2:0] S_PUT   = 3'd5;  // hand the result to the output

  // Outcome of one sift comparison.
  localparam logic [1:0] PICK_NONE  = 2'd0;  // the held entry stays
  localparam logic [1:0] PICK_LEFT  = 2'd1;
  localparam logic [1:0] PICK_RIGHT = 2'd2;

  logic [2:0]                 state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [AW-1:0]              node_r, node_nxt;
  logic [AW-1:0]              fetch_r, fetch_nxt;
  logic [CW-1:0]              build_r, build_nxt;
  logic                       building_r, building_nxt;
  logic                       adv_r, adv_nxt;
  logic [kwm_pkg::VAL_W-1:0]  adv_val_r, adv_val_nxt;
  kwm_pkg::heap_entry_t       hole_r, hole_nxt;
  logic [kwm_pkg::STAT_W-1:0] stat_r, stat_nxt;

  logic                       out_valid_r;
  logic [kwm_pkg::VAL_W-1:0]  out_value_r;
  logic [kwm_pkg::SRC_W-1:0]  out_src_r;
  logic [kwm_pkg::STAT_W-1:0] out_stat_r;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [EW-1:0]              ram_wdata, ram_rdata_a, ram_rdata_b;
  kwm_pkg::heap_entry_t       rd_a, rd_b;

  logic                       in_fire, out_free;
  logic [KW-1:0]              left_w, right_w, cnt_ext;
  logic                       left_ok, right_ok;
  logic [1:0]                 pick;
  logic [AW-1:0]              pick_idx;
  logic [KW-1:0]              pick_left, pick_right;

  kwm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_LISTS)
  ) u_heap (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign rd_a = kwm_pkg::heap_entry_t'(ram_rdata_a);
  assign rd_b = kwm_pkg::heap_entry_t'(ram_rdata_b);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Children of the node being sifted, and whether they lie inside the heap.
  assign cnt_ext  = {{(KW-CW){1'b0}}, cnt_r};
  assign left_w   = {1'b0, node_r, 1'b1};
  assign right_w  = left_w + KW'(1);
  assign left_ok  = left_w < cnt_ext;
  assign right_ok = right_w < cnt_ext;

  // Strict comparisons: the parent keeps its place on a tie, then the left
  // child wins over the right one.
  always_comb begin
    logic signed [kwm_pkg::VAL_W-1:0] best_val;
    pick     = PICK_NONE;
    best_val = $signed(hole_r.val);
    if (left_ok && ($signed(rd_a.val) < best_val)) begin
      pick     = PICK_LEFT;
      best_val = $signed(rd_a.val);
    end
    if (right_ok && ($signed(rd_b.val) < best_val)) begin
      pick = PICK_RIGHT;
    end
  end

  assign pick_idx   = (pick == PICK_RIGHT) ? right_w[AW-1:0] : left_w[AW-1:0];
  assign pick_left  = {1'b0, pick_idx, 1'b1};
  assign pick_right = pick_left + KW'(1);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    node_nxt     = node_r;
    fetch_nxt    = fetch_r;
    build_nxt    = build_r;
    building_nxt = building_r;
    adv_nxt      = adv_r;
    adv_val_nxt  = adv_val_r;
    hole_nxt     = hole_r;
    stat_nxt     = stat_r;
    ram_we       = 1'b0;
    ram_waddr    = node_r;
    ram_wdata    = hole_r;
    ram_raddr_a  = fetch_r;
    ram_raddr_b  = fetch_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_PUT;
          stat_nxt  = kwm_pkg::ST_ACCEPTED;
          adv_nxt   = 1'b0;
          case (in_ch.cmd)
            kwm_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            kwm_pkg::CMD_LOAD: begin
              if (cnt_r >= CW'(MAX_LISTS)) begin
                stat_nxt = kwm_pkg::ST_FULL;
              end else begin
                // Heads are appended in arrival order; start orders them.
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = {in_ch.list_id, in_ch.value};
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            kwm_pkg::CMD_START: begin
              if (cnt_r == '0) begin
                stat_nxt = kwm_pkg::ST_EMPTY;
              end else begin
                stat_nxt = kwm_pkg::ST_VALID;
                if (cnt_r == CW'(1)) begin
                  state_nxt = S_ROOT;
                end else begin
                  // Bottom-up build: sift every inner node, last one first.
                  build_nxt    = cnt_r >> 1;
                  building_nxt = 1'b1;
                  node_nxt     = AW'((cnt_r >> 1) - CW'(1));
                  fetch_nxt    = AW'((cnt_r >> 1) - CW'(1));
                  state_nxt    = S_FETCH;
                end
              end
            end
            kwm_pkg::CMD_ADVANCE: begin
              if (cnt_r == '0) begin
                stat_nxt = kwm_pkg::ST_EMPTY;
              end else begin
                // The root keeps its list number and takes the new value.
                stat_nxt    = kwm_pkg::ST_VALID;
                adv_nxt     = 1'b1;
                adv_val_nxt = in_ch.value;
                node_nxt    = '0;
                fetch_nxt   = '0;
                state_nxt   = S_FETCH;
              end
            end
            kwm_pkg::CMD_EXHAUSTED: begin
              if (cnt_r <= CW'(1)) begin
                cnt_nxt  = '0;
                stat_nxt = kwm_pkg::ST_EMPTY;
              end else begin
                // The last entry replaces the root and the heap shrinks.
                stat_nxt  = kwm_pkg::ST_VALID;
                cnt_nxt   = cnt_r - CW'(1);
                fetch_nxt = AW'(cnt_r - CW'(1));
                node_nxt  = '0;
                state_nxt = S_FETCH;
              end
            end
            default: begin
              stat_nxt = kwm_pkg::ST_ACCEPTED;
            end
          endcase
        end
      end
      S_FETCH: begin
        ram_raddr_a = fetch_r;
        state_nxt   = S_TAKE;
      end
      S_TAKE: begin
        hole_nxt = rd_a;
        if (adv_r) begin
          hole_nxt.val = adv_val_r;
        end
        ram_raddr_a = left_w[AW-1:0];
        ram_raddr_b = right_w[AW-1:0];
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = node_r;
        if (pick != PICK_NONE) begin
          // The smaller child moves up; the held entry goes one level down.
          ram_wdata   = (pick == PICK_RIGHT) ? rd_b : rd_a;
          node_nxt    = pick_idx;
          ram_raddr_a = pick_left[AW-1:0];
          ram_raddr_b = pick_right[AW-1:0];
        end else begin
          ram_wdata = hole_r;
          if (building_r && (build_r > CW'(1))) begin
            build_nxt = build_r - CW'(1);
            node_nxt  = AW'(build_r - CW'(2));
            fetch_nxt = AW'(build_r - CW'(2));
            state_nxt = S_FETCH;
          end else begin
            building_nxt = 1'b0;
            state_nxt    = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        ram_raddr_a = '0;
        state_nxt   = S_PUT;
      end
      S_PUT: begin
        // Port A stays on the root so its data holds while the output waits.
        ram_raddr_a = '0;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      building_r  <= 1'b0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      building_r <= building_nxt;
      adv_r      <= adv_nxt;
      if ((state_r == S_PUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    fetch_r   <= fetch_nxt;
    build_r   <= build_nxt;
    adv_val_r <= adv_val_nxt;
    hole_r    <= hole_nxt;
    stat_r    <= stat_nxt;
    if ((state_r == S_PUT) && out_free) begin
      out_stat_r <= stat_r;
      if (stat_r == kwm_pkg::ST_VALID) begin
        out_value_r <= rd_a.val;
        out_src_r   <= rd_a.src;
      end else begin
        out_value_r <= '0;
        out_src_r   <= '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.source_list = out_src_r;
  assign out_ch.status      = out_stat_r;

  // The entry count never passes the heap size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LISTS))
    else $error("heap entry count above capacity");

  // A sift only ever works on a node inside the heap.
  a_node_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (KW'(node_r) < cnt_ext))
    else $error("sift node outside the heap");

  // A load into a heap with room grows it by exactly one entry.
  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.cmd == kwm_pkg::CMD_LOAD) && (cnt_r < CW'(MAX_LISTS)))
      |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("accepted load did not add an entry");

  // Only a valid root carries a value and a list number.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r != kwm_pkg::ST_VALID))
      |-> ((out_value_r == '0) && (out_src_r == '0)))
    else $error("payload not zero on a status-only result");

endmodule

FILE: src/kwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: tb/kwm_merge_tracker_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_tracker_pkg: expected result tracking for the merge heap unit
// Keeps its own copy of the heap and checks each result word in order.
// ----------------------------------------------------------------------------
package kwm_merge_tracker_pkg;
  import kwm_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] root_value;
    logic [SRC_W-1:0]        root_list;
    logic [STAT_W-1:0]       status;
  } root_report_t;

  class merge_tracker;
    logic signed [VAL_W-1:0] heap_value [MAX_LISTS_DEF];
    logic [SRC_W-1:0]        heap_list  [MAX_LISTS_DEF];
    int                      entry_total;
    root_report_t            expected_reports [$];
    int                      mismatches;

    function new();
      foreach (heap_value[i]) begin
        heap_value[i] = '0;
        heap_list[i]  = '0;
      end
      entry_total = 0;
      mismatches  = 0;
    endfunction

    // Ties keep the parent; the right child only wins if strictly smaller.
    function void sift_down(int node);
      int kid_l;
      int kid_r;
      int best;
      logic signed [VAL_W-1:0] tmp_value;
      logic [SRC_W-1:0]        tmp_list;
      while (node < entry_total) begin
        kid_l = 2 * node + 1;
        kid_r = 2 * node + 2;
        best  = node;
        if (kid_l < entry_total && heap_value[kid_l] < heap_value[best]) best = kid_l;
        if (kid_r < entry_total && heap_value[kid_r] < heap_value[best]) best = kid_r;
        if (best == node) break;
        tmp_value        = heap_value[node];
        tmp_list         = heap_list[node];
        heap_value[node] = heap_value[best];
        heap_list[node]  = heap_list[best];
        heap_value[best] = tmp_value;
        heap_list[best]  = tmp_list;
        node = best;
      end
    endfunction

    function void push_report(logic [STAT_W-1:0] status);
      root_report_t rep;
      rep.status     = status;
      rep.root_value = (status == ST_VALID) ? heap_value[0] : '0;
      rep.root_list  = (status == ST_VALID) ? heap_list[0] : '0;
      expected_reports.insert(expected_reports.size(), rep);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [SRC_W-1:0] id,
                               logic signed [VAL_W-1:0] val);
      int i;
      case (cmd)
        CMD_CLEAR: begin
          entry_total = 0;
          push_report(ST_ACCEPTED);
        end
        CMD_LOAD: begin
          if (entry_total >= MAX_LISTS_DEF) begin
            push_report(ST_FULL);
          end else begin
            heap_value[entry_total] = val;
            heap_list[entry_total]  = id;
            entry_total++;
            push_report(ST_ACCEPTED);
          end
        end
        CMD_START: begin
          if (entry_total == 0) begin
            push_report(ST_EMPTY);
          end else begin
            for (i = entry_total / 2; i >= 1; i--) sift_down(i - 1);
            push_report(ST_VALID);
          end
        end
        CMD_ADVANCE: begin
          if (entry_total == 0) begin
            push_report(ST_EMPTY);
          end else begin
            heap_value[0] = val;
            sift_down(0);
            push_report(ST_VALID);
          end
        end
        CMD_EXHAUSTED: begin
          if (entry_total <= 1) begin
            entry_total = 0;
            push_report(ST_EMPTY);
          end else begin
            entry_total--;
            heap_value[0] = heap_value[entry_total];
            heap_list[0]  = heap_list[entry_total];
            sift_down(0);
            push_report(ST_VALID);
          end
        end
        default: push_report(ST_ACCEPTED);
      endcase
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic [SRC_W-1:0] list,
                               logic [STAT_W-1:0] status);
      root_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result word: value %0d list %0d status %0d",
                 $time, value, list, status);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (value !== want.root_value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, want.root_value, value);
        mismatches++;
      end
      if (list !== want.root_list) begin
        $display("%0t: source_list expected %0d actual %0d", $time, want.root_list, list);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_kway_merge_min_heap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kway_merge_min_heap_unit: self-checking bench for the k-way merge heap
// Drives command words, mirrors the heap in a tracker and checks each result.
// ----------------------------------------------------------------------------
// A short directed opening covers empty-heap commands, unused codes, a full
// heap, a refused load, advance before start and the last exhausted list.
// The random part is mostly complete merges (clear, loads, start, then
// advances and exhausted commands until the heap is empty) with value sets
// chosen to be wide, tie-heavy or extreme, mixed with bursts of noise words.
module tb_kway_merge_min_heap_unit;
  import kwm_pkg::*;
  import kwm_merge_tracker_pkg::*;

  // A start on 16 entries runs 8 sifts; with sender gaps, receiver stalls and
  // the long hold this limit is very loose.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_START   = 2000;
  localparam int HOLD_LENGTH  = 400;

  logic clk;
  logic rst_n;

  kwm_in_if  in_if ();
  kwm_out_if out_if ();

  kway_merge_min_heap_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  merge_tracker tracker;

  int          cycle_count   = 0;
  int          rx_cycle      = 0;
  logic [31:0] stall_mask    = '0;
  logic        always_ready  = 1'b0;
  int          burst_left    = 0;
  int          words_counted = 0;

  // Head values for the directed full-heap load: extremes, zero, minus one and
  // repeated values so that the tie rules of the sift-down come into play.
  logic signed [VAL_W-1:0] head_seed [16] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd5, 32'sd5, 32'sd5, -32'sd7,
    32'sd100, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd3, 32'sd3, -32'sd1, 32'sd0, 32'sd42
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side. Every accepted result word goes to the tracker. Ready follows
  // a random stall mask that is redrawn during the run; a quarter of the time
  // the receiver simply takes everything. One long hold-off in the middle of
  // the run lets the output register fill so that the unit has to stall its
  // input while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_result(out_if.out_value, out_if.source_list, out_if.status);
    if (rx_cycle % 128 == 0) begin
      stall_mask   = $urandom() & $urandom();
      always_ready = ($urandom_range(0, 3) == 0);
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LENGTH) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= always_ready | ~stall_mask[rx_cycle % 32];
    end
    rx_cycle = rx_cycle + 1;
  end

  // Offers one command word and waits until the unit takes it. The sender works
  // in bursts; between bursts it drops valid for a random gap, and sometimes
  // it goes straight on so that back-to-back words are covered too. The valid
  // line is only lowered when a gap follows, so it never toggles in one step.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] id,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    in_if.valid   <= 1'b1;
    in_if.cmd     <= cmd;
    in_if.list_id <= id;
    in_if.value   <= val;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_command(cmd, id, val);
    // Unused command codes only get an accepted status from the unit and do not count.
    if (cmd <= CMD_EXHAUSTED) words_counted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Flavor 0 gives full-range values, 1 a narrow band full of ties, 2 only
  // the extremes, zero and minus one.
  function automatic logic signed [VAL_W-1:0] pick_value(int flavor);
    logic signed [VAL_W-1:0] v;
    case (flavor)
      0: v = $urandom();
      1: v = $urandom_range(0, 8) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // One complete merge: fill the heap, build it, then pull lists forward until
  // every list is exhausted. Now and then more heads than fit are offered so
  // that refused loads show up inside otherwise normal merges.
  task automatic run_merge();
    int flavor;
    int heads;
    int remaining;
    int advances;
    int i;
    flavor = $urandom_range(0, 2);
    heads  = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 16);
    send_word(CMD_CLEAR, SRC_W'($urandom_range(0, 15)), pick_value(0));
    for (i = 0; i < heads; i++)
      send_word(CMD_LOAD, SRC_W'($urandom_range(0, 15)), pick_value(flavor));
    send_word(CMD_START, SRC_W'($urandom_range(0, 15)), pick_value(0));
    remaining = (heads > MAX_LISTS_DEF) ? MAX_LISTS_DEF : heads;
    advances  = 0;
    while (remaining > 0) begin
      if (advances < 3 * heads && $urandom_range(0, 9) < 6) begin
        send_word(CMD_ADVANCE, SRC_W'($urandom_range(0, 15)), pick_value(flavor));
        advances++;
      end else begin
        send_word(CMD_EXHAUSTED, SRC_W'($urandom_range(0, 15)), pick_value(0));
        remaining--;
      end
    end
  endtask

  // Noise: any command code in any order, including loads after a start,
  // advances on an empty heap and the unused codes.
  task automatic run_noise();
    int n;
    int i;
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++)
      send_word(CMD_W'($urandom_range(0, 7)), SRC_W'($urandom_range(0, 15)),
                pick_value($urandom_range(0, 2)));
  endtask

  initial begin
    int i;
    tracker = new();
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.cmd     <= CMD_CLEAR;
    in_if.list_id <= '0;
    in_if.value   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Commands on an empty heap report it, unused codes are
    // accepted without a value.
    send_word(CMD_ADVANCE, 4'hf, 32'sh7fff_ffff);
    send_word(CMD_EXHAUSTED, 4'h0, 32'sd0);
    send_word(CMD_START, 4'h0, 32'sd0);
    send_word(3'd7, 4'ha, 32'sh5555_aaaa);
    send_word(CMD_CLEAR, 4'h5, 32'sh0f0f_0f0f);
    // Fill the heap with every list number, then try one load too many.
    for (i = 0; i < 16; i++)
      send_word(CMD_LOAD, SRC_W'(i), head_seed[i]);
    send_word(CMD_LOAD, 4'h9, 32'sd1);
    // Advance before start only sifts the root through the unordered entries.
    send_word(CMD_ADVANCE, 4'h0, 32'sh7fff_ffff);
    send_word(CMD_START, 4'h0, 32'sd0);
    send_word(CMD_ADVANCE, 4'h0, 32'sh8000_0000);
    send_word(CMD_EXHAUSTED, 4'h0, 32'sd0);
    send_word(3'd5, 4'h3, -32'sd1);
    // Exhausting the only list left empties the heap.
    send_word(CMD_CLEAR, 4'h0, 32'sd0);
    send_word(CMD_LOAD, 4'hc, -32'sd1);
    send_word(CMD_EXHAUSTED, 4'h0, 32'sd0);

    words_counted = 0;
    while (words_counted < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 80) run_merge();
      else run_noise();
    end
    in_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    // Let any stray word that the unit might still produce show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
